@@ hw/rtl/matrix_multiply_top_defines.svh @@
// Assertion macros for the matrix multiply block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MM_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("matrix multiply check failed");

// Next-cycle implication, disabled while reset is high.
`define MM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("matrix multiply check failed");

`endif

@@ hw/rtl/mm_pkg.sv @@
// Shared types and constants for the matrix multiply block.
// No dependencies; used by every module of the block except mm_ram.
`default_nettype none

package mm_pkg;

   localparam int IDX_W     = 3;
   localparam int VAL_W     = 32;
   localparam int DIM_W     = 4;
   localparam int ACC_W     = 64;
   localparam int FRAC_BITS = 16;

   localparam logic [1:0] CMD_WRITE_A = 2'd0;
   localparam logic [1:0] CMD_WRITE_B = 2'd1;
   localparam logic [1:0] CMD_START   = 2'd2;

   localparam logic [1:0] REG_ROWS_A     = 2'd0;
   localparam logic [1:0] REG_COMMON_DIM = 2'd1;
   localparam logic [1:0] REG_COLS_B     = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_DRAIN
   } seq_state_type;

   // Effective dimensions after clamping.
   typedef struct packed {
      logic [DIM_W-1:0] nr;
      logic [DIM_W-1:0] nk;
      logic [DIM_W-1:0] nc;
   } dims_type;

   // Tag that travels with one multiply-accumulate slot.
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             lastk;
      logic             zero;
      logic             lastelem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } issue_tag_type;

endpackage

`default_nettype wire

@@ hw/rtl/matrix_multiply_top.sv @@
// Matrix multiply C = A * B in Q16.16: loads write straight into the stores, busy stays low.
// A start runs nr*nc*max(nk,1) MAC slots via RAM read, product, accumulator and
// output registers; one result per C element, busy drops the cycle after the last.
// The receiver cannot stall: results stream out on rsp_strobe as they finish.
// Synchronous active-high reset sets all dimensions to 8; stores are not cleared.
// Depends on mm_pkg, mm_ram, mm_seq, mm_mac and matrix_multiply_top_defines.svh.
`default_nettype none
`include "matrix_multiply_top_defines.svh"

module matrix_multiply_top #(
   parameter int DIM = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input item channel
   input  wire logic                            start,
   output      logic                            busy,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [mm_pkg::IDX_W-1:0]        req_row,
   input  wire logic [mm_pkg::IDX_W-1:0]        req_col,
   input  wire logic signed [mm_pkg::VAL_W-1:0] req_value,
   // result channel
   output      logic                            rsp_strobe,
   output      logic [mm_pkg::IDX_W-1:0]        rsp_out_row,
   output      logic [mm_pkg::IDX_W-1:0]        rsp_out_col,
   output      logic signed [mm_pkg::VAL_W-1:0] rsp_product,
   output      logic                            rsp_last,
   // configuration port
   input  wire logic                            csr_we,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [mm_pkg::DIM_W-1:0]        csr_wdata
);

   localparam int DEPTH     = DIM * DIM;
   localparam int AW        = $clog2(DEPTH);
   localparam int IDX_LIMIT = (DIM < 8) ? DIM : 8;
   localparam logic [mm_pkg::DIM_W-1:0] LIMIT_V = mm_pkg::DIM_W'(IDX_LIMIT);

   logic [mm_pkg::DIM_W-1:0] rows_a_ff, common_dim_ff, cols_b_ff;
   mm_pkg::dims_type         dims;
   mm_pkg::issue_tag_type    tag;

   logic          accept;
   logic          go;
   logic          a_we, b_we;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic [mm_pkg::VAL_W-1:0] a_data, b_data;
   logic          row_in_r, row_in_k, col_in_k, col_in_c;

   // Configuration registers: take writes at any time, ignore unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff     <= mm_pkg::DIM_RESET;
         common_dim_ff <= mm_pkg::DIM_RESET;
         cols_b_ff     <= mm_pkg::DIM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mm_pkg::REG_ROWS_A:     rows_a_ff     <= csr_wdata;
            mm_pkg::REG_COMMON_DIM: common_dim_ff <= csr_wdata;
            mm_pkg::REG_COLS_B:     cols_b_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Clamp each dimension to what the 3-bit indexes and the store can address.
   assign dims.nr = (rows_a_ff     < LIMIT_V) ? rows_a_ff     : LIMIT_V;
   assign dims.nk = (common_dim_ff < LIMIT_V) ? common_dim_ff : LIMIT_V;
   assign dims.nc = (cols_b_ff     < LIMIT_V) ? cols_b_ff     : LIMIT_V;

   assign accept = start && !busy;
   assign go     = accept && (req_cmd == mm_pkg::CMD_START);

   // Range checks for loads: drop an item that falls outside its matrix.
   assign row_in_r = mm_pkg::DIM_W'(req_row) < dims.nr;
   assign row_in_k = mm_pkg::DIM_W'(req_row) < dims.nk;
   assign col_in_k = mm_pkg::DIM_W'(req_col) < dims.nk;
   assign col_in_c = mm_pkg::DIM_W'(req_col) < dims.nc;

   always_comb begin
      a_we = 1'b0;
      b_we = 1'b0;
      case (req_cmd)
         mm_pkg::CMD_WRITE_A: a_we = accept && row_in_r && col_in_k;
         mm_pkg::CMD_WRITE_B: b_we = accept && row_in_k && col_in_c;
         default: begin
         end
      endcase
   end

   // Row-major placement with a row pitch of DIM.
   assign wr_addr = AW'(req_row) * AW'(DIM) + AW'(req_col);

   mm_ram #(
      .WIDTH (mm_pkg::VAL_W),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr_a),
      .rd_data (a_data)
   );

   mm_ram #(
      .WIDTH (mm_pkg::VAL_W),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr_b),
      .rd_data (b_data)
   );

   // Sequencer issues one MAC slot per cycle; hold busy until the last item drains.
   mm_seq #(
      .DIM (DIM)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .dims       (dims),
      .drain_done (rsp_strobe && rsp_last),
      .busy       (busy),
      .tag        (tag),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b)
   );

   // Shared multiplier and 64-bit accumulator; scale, saturate and emit.
   mm_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .tag         (tag),
      .a_data      (a_data),
      .b_data      (b_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col),
      .rsp_product (rsp_product),
      .rsp_last    (rsp_last)
   );

   // Results appear only while a job is in flight.
   `MM_ASSERT_NOW(a_strobe_busy, clock, reset, rsp_strobe, busy)
   // Slots are issued only while busy.
   `MM_ASSERT_NOW(a_issue_busy, clock, reset, tag.valid, busy)
   // Nothing is left in the pipeline when a new item is taken.
   `MM_ASSERT_NEXT(a_accept_clean, clock, reset, accept, !rsp_strobe)
   // The final result ends the job.
   `MM_ASSERT_NEXT(a_last_idle, clock, reset, rsp_strobe && rsp_last, !busy)

endmodule

`default_nettype wire

@@ hw/rtl/mm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mm_seq.sv @@
// Index sequencer: walks row, column and inner index, issues RAM reads and tags.
// Depends on mm_pkg.
`default_nettype none

module mm_seq #(
   parameter int DIM = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire mm_pkg::dims_type              dims,
   input  wire logic                          drain_done,
   output      logic                          busy,
   output      mm_pkg::issue_tag_type         tag,
   output      logic [$clog2(DIM*DIM)-1:0]    rd_addr_a,
   output      logic [$clog2(DIM*DIM)-1:0]    rd_addr_b
);

   localparam int AW = $clog2(DIM*DIM);

   mm_pkg::seq_state_type state_ff, state_in;
   logic [mm_pkg::IDX_W-1:0] r_ff, r_in;
   logic [mm_pkg::IDX_W-1:0] c_ff, c_in;
   logic [mm_pkg::IDX_W-1:0] k_ff, k_in;

   logic at_lastk, at_lastc, at_lastr, empty_job;

   assign at_lastk  = (dims.nk == '0) ||
                      ((mm_pkg::DIM_W'(k_ff) + mm_pkg::DIM_W'(1)) == dims.nk);
   assign at_lastc  = (mm_pkg::DIM_W'(c_ff) + mm_pkg::DIM_W'(1)) == dims.nc;
   assign at_lastr  = (mm_pkg::DIM_W'(r_ff) + mm_pkg::DIM_W'(1)) == dims.nr;
   assign empty_job = (dims.nr == '0) || (dims.nc == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mm_pkg::SEQ_IDLE: begin
            if (go && !empty_job) begin
               state_in = mm_pkg::SEQ_RUN;
            end
         end
         mm_pkg::SEQ_RUN: begin
            if (at_lastk && at_lastc && at_lastr) begin
               state_in = mm_pkg::SEQ_DRAIN;
            end
         end
         mm_pkg::SEQ_DRAIN: begin
            if (drain_done) begin
               state_in = mm_pkg::SEQ_IDLE;
            end
         end
         default: state_in = mm_pkg::SEQ_IDLE;
      endcase
   end

   // Outputs and counters.
   always_comb begin
      r_in = r_ff;
      c_in = c_ff;
      k_in = k_ff;
      tag  = '0;
      busy = (state_ff != mm_pkg::SEQ_IDLE);
      case (state_ff)
         mm_pkg::SEQ_IDLE: begin
            r_in = '0;
            c_in = '0;
            k_in = '0;
         end
         mm_pkg::SEQ_RUN: begin
            tag.valid    = 1'b1;
            tag.first    = (k_ff == '0);
            tag.lastk    = at_lastk;
            tag.zero     = (dims.nk == '0);
            tag.lastelem = at_lastc && at_lastr;
            tag.row      = r_ff;
            tag.col      = c_ff;
            if (at_lastk) begin
               k_in = '0;
               if (at_lastc) begin
                  c_in = '0;
                  r_in = r_ff + 1'b1;
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         mm_pkg::SEQ_DRAIN: begin
         end
         default: begin
         end
      endcase
   end

   assign rd_addr_a = AW'(r_ff) * AW'(DIM) + AW'(k_ff);
   assign rd_addr_b = AW'(k_ff) * AW'(DIM) + AW'(c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      r_ff <= r_in;
      c_ff <= c_in;
      k_ff <= k_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/mm_mac.sv @@
// Shared multiply-accumulate unit with scale and saturate on the result register.
// Depends on mm_pkg.
`default_nettype none

module mm_mac (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mm_pkg::issue_tag_type         tag,
   input  wire logic [mm_pkg::VAL_W-1:0]      a_data,
   input  wire logic [mm_pkg::VAL_W-1:0]      b_data,
   output      logic                          rsp_strobe,
   output      logic [mm_pkg::IDX_W-1:0]      rsp_out_row,
   output      logic [mm_pkg::IDX_W-1:0]      rsp_out_col,
   output      logic signed [mm_pkg::VAL_W-1:0] rsp_product,
   output      logic                          rsp_last
);

   localparam int SAT_LO = mm_pkg::FRAC_BITS + mm_pkg::VAL_W - 1;

   mm_pkg::issue_tag_type s1_tag_ff, s2_tag_ff;
   logic [mm_pkg::ACC_W-1:0] prod_ff, prod_in;
   logic [mm_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                     acc_done_ff;
   logic                     acc_last_ff;
   logic [mm_pkg::IDX_W-1:0] acc_row_ff, acc_col_ff;
   logic [mm_pkg::VAL_W-1:0] sat_value;
   logic                     fits;

   assign prod_in = s1_tag_ff.zero ? '0 :
                    mm_pkg::ACC_W'($signed(a_data) * $signed(b_data));

   assign acc_in = (s2_tag_ff.first ? '0 : acc_ff) + prod_ff;

   // Fits in 32 bits when the bits above the kept window all match the sign.
   assign fits = (acc_ff[mm_pkg::ACC_W-1:SAT_LO] == '0) ||
                 (acc_ff[mm_pkg::ACC_W-1:SAT_LO] == '1);

   always_comb begin
      if (fits) begin
         sat_value = acc_ff[SAT_LO:mm_pkg::FRAC_BITS];
      end else if (acc_ff[mm_pkg::ACC_W-1]) begin
         sat_value = {1'b1, {(mm_pkg::VAL_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(mm_pkg::VAL_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff   <= '0;
         s2_tag_ff   <= '0;
         acc_done_ff <= 1'b0;
         rsp_strobe  <= 1'b0;
      end else begin
         s1_tag_ff   <= tag;
         s2_tag_ff   <= s1_tag_ff;
         acc_done_ff <= s2_tag_ff.valid && s2_tag_ff.lastk;
         rsp_strobe  <= acc_done_ff;
      end
      prod_ff <= prod_in;
      if (s2_tag_ff.valid) begin
         acc_ff      <= acc_in;
         acc_row_ff  <= s2_tag_ff.row;
         acc_col_ff  <= s2_tag_ff.col;
         acc_last_ff <= s2_tag_ff.lastelem;
      end
      rsp_out_row <= acc_row_ff;
      rsp_out_col <= acc_col_ff;
      rsp_product <= sat_value;
      rsp_last    <= acc_last_ff;
   end

endmodule

`default_nettype wire

@@ tb/sv/mm_tb_pkg.sv @@
// Scoreboard for the matrix multiply testbench: mirrors the A and B stores,
// predicts every C element of a start item and checks the streamed results.
// Depends on mm_pkg.
`timescale 1ns / 100ps

package mm_tb_pkg;

   localparam int         STORE_DIM  = 8;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [mm_pkg::IDX_W-1:0] row;
      logic [mm_pkg::IDX_W-1:0] col;
      logic [mm_pkg::VAL_W-1:0] product;
      logic                     last;
   } c_elem_type;

   class c_matrix_tracker_type;
      logic signed [mm_pkg::VAL_W-1:0] a_mem [STORE_DIM*STORE_DIM];
      logic signed [mm_pkg::VAL_W-1:0] b_mem [STORE_DIM*STORE_DIM];
      bit                              a_set [STORE_DIM*STORE_DIM];
      bit                              b_set [STORE_DIM*STORE_DIM];
      logic [mm_pkg::DIM_W-1:0]        rows_a;
      logic [mm_pkg::DIM_W-1:0]        common_dim;
      logic [mm_pkg::DIM_W-1:0]        cols_b;
      c_elem_type                      pending_elems [$];
      int                              errors;

      function new();
         rows_a     = mm_pkg::DIM_RESET;
         common_dim = mm_pkg::DIM_RESET;
         cols_b     = mm_pkg::DIM_RESET;
         errors     = 0;
         foreach (a_set[i]) begin
            a_set[i] = 1'b0;
            b_set[i] = 1'b0;
         end
      endfunction

      // Indices are 3 bits wide, so sizes above eight act as eight.
      function int eff_size(logic [mm_pkg::DIM_W-1:0] v);
         return (v > 4'd8) ? STORE_DIM : int'(v);
      endfunction

      function void set_reg(logic [1:0] idx, logic [mm_pkg::DIM_W-1:0] v);
         case (idx)
            mm_pkg::REG_ROWS_A:     rows_a = v;
            mm_pkg::REG_COMMON_DIM: common_dim = v;
            mm_pkg::REG_COLS_B:     cols_b = v;
            default: ;
         endcase
      endfunction

      function bit in_range(logic [1:0] cmd, logic [mm_pkg::IDX_W-1:0] row,
                            logic [mm_pkg::IDX_W-1:0] col);
         case (cmd)
            mm_pkg::CMD_WRITE_A:
               return row < eff_size(rows_a) && col < eff_size(common_dim);
            mm_pkg::CMD_WRITE_B:
               return row < eff_size(common_dim) && col < eff_size(cols_b);
            default: return 1'b0;
         endcase
      endfunction

      function void note_failure(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      // Arithmetic shift by the fraction width, then clip to 32 signed bits.
      function logic [mm_pkg::VAL_W-1:0] scale_q16(logic signed [mm_pkg::ACC_W-1:0] acc);
         logic signed [mm_pkg::ACC_W-1:0] s;
         s = acc >>> mm_pkg::FRAC_BITS;
         if (s[mm_pkg::ACC_W-1:mm_pkg::VAL_W-1] ==
             {(mm_pkg::ACC_W-mm_pkg::VAL_W+1){s[mm_pkg::ACC_W-1]}})
            return s[mm_pkg::VAL_W-1:0];
         return s[mm_pkg::ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      endfunction

      function void compute_c();
         int                              nr, nk, nc;
         logic signed [mm_pkg::ACC_W-1:0] acc, x, y;
         c_elem_type                      e;
         nr = eff_size(rows_a);
         nk = eff_size(common_dim);
         nc = eff_size(cols_b);
         for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
               acc = '0;
               for (int k = 0; k < nk; k++) begin
                  x   = a_mem[r*STORE_DIM+k];
                  y   = b_mem[k*STORE_DIM+c];
                  acc = acc + x * y;
               end
               e.row     = mm_pkg::IDX_W'(r);
               e.col     = mm_pkg::IDX_W'(c);
               e.product = scale_q16(acc);
               e.last    = (r == nr - 1) && (c == nc - 1);
               pending_elems.push_back(e);
            end
         end
      endfunction

      function void record_item(logic [1:0] cmd, logic [mm_pkg::IDX_W-1:0] row,
                                logic [mm_pkg::IDX_W-1:0] col,
                                logic [mm_pkg::VAL_W-1:0] value);
         case (cmd)
            mm_pkg::CMD_WRITE_A: if (in_range(cmd, row, col)) begin
               a_mem[row*STORE_DIM+col] = value;
               a_set[row*STORE_DIM+col] = 1'b1;
            end
            mm_pkg::CMD_WRITE_B: if (in_range(cmd, row, col)) begin
               b_mem[row*STORE_DIM+col] = value;
               b_set[row*STORE_DIM+col] = 1'b1;
            end
            mm_pkg::CMD_START: compute_c();
            default: ;
         endcase
      endfunction

      function void check_element(logic [mm_pkg::IDX_W-1:0] row,
                                  logic [mm_pkg::IDX_W-1:0] col,
                                  logic [mm_pkg::VAL_W-1:0] product, logic last);
         c_elem_type want;
         if (pending_elems.size() == 0) begin
            note_failure($sformatf("unexpected C element: row %0d col %0d value %h last %b",
                                   row, col, product, last));
            return;
         end
         want = pending_elems.pop_front();
         if (row !== want.row || col !== want.col || product !== want.product ||
             last !== want.last)
            note_failure($sformatf({"C element mismatch: expected row %0d col %0d value %h ",
                                    "last %b, got row %0d col %0d value %h last %b"},
                                   want.row, want.col, want.product, want.last,
                                   row, col, product, last));
      endfunction
   endclass

endpackage

@@ tb/sv/tb_matrix_multiply_top.sv @@
// Self-checking testbench for matrix_multiply_top: directed corner jobs, then
// random load/start jobs under three sender idling profiles.
// Depends on mm_pkg, mm_tb_pkg and the matrix multiply RTL.
`timescale 1ns / 100ps

module tb_matrix_multiply_top;

   localparam int ITEM_GOAL    = 500;
   localparam int QUIET_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 4_000_000;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            start     = 1'b0;
   logic                            busy;
   logic [1:0]                      req_cmd   = mm_pkg::CMD_WRITE_A;
   logic [mm_pkg::IDX_W-1:0]        req_row   = '0;
   logic [mm_pkg::IDX_W-1:0]        req_col   = '0;
   logic signed [mm_pkg::VAL_W-1:0] req_value = '0;
   logic                            rsp_strobe;
   logic [mm_pkg::IDX_W-1:0]        rsp_out_row;
   logic [mm_pkg::IDX_W-1:0]        rsp_out_col;
   logic signed [mm_pkg::VAL_W-1:0] rsp_product;
   logic                            rsp_last;
   logic                            csr_we    = 1'b0;
   logic [1:0]                      csr_index = mm_pkg::REG_ROWS_A;
   logic [mm_pkg::DIM_W-1:0]        csr_wdata = mm_pkg::DIM_RESET;

   mm_tb_pkg::c_matrix_tracker_type tracker = new();

   int sender_idle_pct = 18;
   int counted_items   = 0;
   int cycles          = 0;
   int idle_by_phase [3] = '{18, 74, 0};

   always #1 clock = ~clock;

   matrix_multiply_top #(
      .DIM(mm_tb_pkg::STORE_DIM)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_cmd    (req_cmd),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col),
      .rsp_product(rsp_product),
      .rsp_last   (rsp_last),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Watchdog: drop the run if it goes far past any correct schedule.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("matrix_multiply_top regression: fail");
         $finish;
      end
   end

   // Results cannot be held off: check each strobed element on the edge
   // that closes its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         tracker.check_element(rsp_out_row, rsp_out_col, rsp_product, rsp_last);
   end

   // Mix of saturation extremes, zero, small values below 4.0 in magnitude and raw random words.
   function automatic logic [mm_pkg::VAL_W-1:0] rand_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '0;
         3:       return $urandom_range(1) ? 32'($urandom_range(32'h3_FFFF))
                                           : -32'($urandom_range(32'h3_FFFF));
         default: return $urandom;
      endcase
   endfunction

   // Mostly small sizes, some zero, some at or above the clamp.
   function automatic logic [mm_pkg::DIM_W-1:0] pick_dim();
      int p;
      p = $urandom_range(99);
      if (p < 4) return '0;
      if (p < 14) return mm_pkg::DIM_W'($urandom_range(15, 8));
      return mm_pkg::DIM_W'($urandom_range(5, 1));
   endfunction

   // Present one item, after a random idle gap, and hold it until accepted.
   // Start stays high into the next item, so it is assigned once per step.
   task automatic send_item(input logic [1:0] cmd, input logic [mm_pkg::IDX_W-1:0] row,
                            input logic [mm_pkg::IDX_W-1:0] col,
                            input logic [mm_pkg::VAL_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_row   <= row;
      req_col   <= col;
      req_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
      // Loads that the block drops do not count toward the item goal.
      if (cmd == mm_pkg::CMD_START || tracker.in_range(cmd, row, col)) counted_items++;
      tracker.record_item(cmd, row, col, value);
   endtask

   // Drain every expected element, wait for busy to fall, then let the
   // pipeline settle in case a start produced nothing.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (tracker.pending_elems.size() != 0 || busy !== 1'b0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Write all three dimension registers back to back while idle.
   task automatic set_dims(input logic [mm_pkg::DIM_W-1:0] r,
                           input logic [mm_pkg::DIM_W-1:0] k,
                           input logic [mm_pkg::DIM_W-1:0] c);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= mm_pkg::REG_ROWS_A;
      csr_wdata <= r;
      @(posedge clock);
      csr_index <= mm_pkg::REG_COMMON_DIM;
      csr_wdata <= k;
      @(posedge clock);
      csr_index <= mm_pkg::REG_COLS_B;
      csr_wdata <= c;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_reg(mm_pkg::REG_ROWS_A, r);
      tracker.set_reg(mm_pkg::REG_COMMON_DIM, k);
      tracker.set_reg(mm_pkg::REG_COLS_B, c);
   endtask

   // Write every element in use that has never been written, so a start
   // never reads an undefined store entry.
   task automatic fill_missing();
      int nr, nk, nc;
      nr = tracker.eff_size(tracker.rows_a);
      nk = tracker.eff_size(tracker.common_dim);
      nc = tracker.eff_size(tracker.cols_b);
      for (int r = 0; r < nr; r++)
         for (int k = 0; k < nk; k++)
            if (!tracker.a_set[r*mm_tb_pkg::STORE_DIM+k])
               send_item(mm_pkg::CMD_WRITE_A, mm_pkg::IDX_W'(r), mm_pkg::IDX_W'(k),
                         rand_value());
      for (int k = 0; k < nk; k++)
         for (int c = 0; c < nc; c++)
            if (!tracker.b_set[k*mm_tb_pkg::STORE_DIM+c])
               send_item(mm_pkg::CMD_WRITE_B, mm_pkg::IDX_W'(k), mm_pkg::IDX_W'(c),
                         rand_value());
   endtask

   // Mostly in-range loads; some land anywhere, a few use the unused code.
   task automatic send_random_load(input int nr, input int nk, input int nc);
      int         pick, lim_r, lim_c;
      logic [1:0] cmd;
      pick  = $urandom_range(99);
      cmd   = $urandom_range(1) ? mm_pkg::CMD_WRITE_B : mm_pkg::CMD_WRITE_A;
      lim_r = (cmd == mm_pkg::CMD_WRITE_A) ? nr : nk;
      lim_c = (cmd == mm_pkg::CMD_WRITE_A) ? nk : nc;
      if (pick < 5)
         send_item(mm_tb_pkg::CMD_UNUSED, mm_pkg::IDX_W'($urandom),
                   mm_pkg::IDX_W'($urandom), $urandom);
      else if (pick < 20 || lim_r == 0 || lim_c == 0)
         send_item(cmd, mm_pkg::IDX_W'($urandom), mm_pkg::IDX_W'($urandom), rand_value());
      else
         send_item(cmd, mm_pkg::IDX_W'($urandom_range(lim_r - 1)),
                   mm_pkg::IDX_W'($urandom_range(lim_c - 1)), rand_value());
   endtask

   // One job: new sizes, a few loads, complete the operands, multiply;
   // sometimes patch a few elements and multiply again.
   task automatic run_job();
      int nr, nk, nc;
      set_dims(pick_dim(), pick_dim(), pick_dim());
      nr = tracker.eff_size(tracker.rows_a);
      nk = tracker.eff_size(tracker.common_dim);
      nc = tracker.eff_size(tracker.cols_b);
      repeat ($urandom_range(12, 2)) send_random_load(nr, nk, nc);
      fill_missing();
      send_item(mm_pkg::CMD_START, mm_pkg::IDX_W'($urandom), mm_pkg::IDX_W'($urandom),
                $urandom);
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(3, 1)) send_random_load(nr, nk, nc);
         fill_missing();
         send_item(mm_pkg::CMD_START, mm_pkg::IDX_W'($urandom), mm_pkg::IDX_W'($urandom),
                   $urandom);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 2x2x2 with saturating and wrapping sums: row 1 of A times column 0
      // of B adds two 2^62 products, which wraps the accumulator negative.
      set_dims(4'd2, 4'd2, 4'd2);
      send_item(mm_pkg::CMD_WRITE_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
      send_item(mm_pkg::CMD_WRITE_A, 3'd0, 3'd1, 32'h8000_0000);
      send_item(mm_pkg::CMD_WRITE_A, 3'd1, 3'd0, 32'h8000_0000);
      send_item(mm_pkg::CMD_WRITE_A, 3'd1, 3'd1, 32'h8000_0000);
      send_item(mm_pkg::CMD_WRITE_B, 3'd0, 3'd0, 32'h8000_0000);
      send_item(mm_pkg::CMD_WRITE_B, 3'd1, 3'd0, 32'h8000_0000);
      send_item(mm_pkg::CMD_WRITE_B, 3'd0, 3'd1, 32'h7FFF_FFFF);
      send_item(mm_pkg::CMD_WRITE_B, 3'd1, 3'd1, 32'h0001_0000);
      // Out-of-range loads and the unused command must leave C untouched.
      send_item(mm_pkg::CMD_WRITE_A, 3'd7, 3'd7, 32'h1234_5678);
      send_item(mm_pkg::CMD_WRITE_B, 3'd0, 3'd7, 32'h0BAD_0BAD);
      send_item(mm_tb_pkg::CMD_UNUSED, 3'd1, 3'd1, 32'hFFFF_FFFF);
      send_item(mm_pkg::CMD_START, 3'd0, 3'd0, '0);

      // Zero rows, then zero columns: a start yields nothing.
      set_dims(4'd0, 4'd2, 4'd2);
      send_item(mm_pkg::CMD_START, 3'd7, 3'd7, '0);
      set_dims(4'd2, 4'd2, 4'd0);
      send_item(mm_pkg::CMD_START, 3'd0, 3'd0, '0);
      // Zero common dimension: every element is zero.
      set_dims(4'd2, 4'd0, 4'd2);
      send_item(mm_pkg::CMD_START, 3'd0, 3'd0, '0);
      // Sizes above eight clamp to eight: a full 8x8 outer product.
      set_dims(4'd15, 4'd1, 4'd9);
      fill_missing();
      send_item(mm_pkg::CMD_START, 3'd0, 3'd0, '0);

      counted_items = 0;
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = idle_by_phase[phase];
         while (counted_items < ITEM_GOAL * (phase + 1) / 3) run_job();
      end

      wait_idle();
      if (tracker.pending_elems.size() != 0)
         tracker.note_failure($sformatf("%0d C elements never arrived",
                                        tracker.pending_elems.size()));
      if (tracker.errors == 0)
         $display("matrix_multiply_top regression: pass");
      else
         $display("matrix_multiply_top regression: fail");
      $finish;
   end

endmodule
